/* rtl/ptuc_pkg.sv */
// Shared types, widths and constants for the perceptron training block.
package ptuc_pkg;

	localparam int WEIGHT_W  = 16;
	localparam int ACC_W     = 19;
	localparam int NUM_W     = 5;
	localparam int IDX_W     = 3;
	localparam int RATE_W    = 12;
	localparam int CORR_W    = 12;

	localparam logic [IDX_W-1:0]  BIAS_IDX   = IDX_W'(NUM_W - 1);
	localparam logic [CORR_W-1:0] CORR_MAX   = {CORR_W{1'b1}};
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(123);

	localparam int DEF_MAX_EPOCHS = 4095;
	localparam int DEF_FRAC_BITS  = 12;

	typedef struct packed {
		logic tame_flag;
		logic prey_size;
		logic body_size;
		logic habitat_wild;
		logic desired_class;
	} item_t;

	typedef struct packed {
		logic              first_class;
		logic [CORR_W-1:0] corrections;
		logic              cap_hit;
		logic              final_class;
	} result_t;

	typedef struct packed {
		logic accumulate;
		logic active;
	} alu_ctrl_t;

endpackage

/* rtl/ptuc_alu.sv */
// Shared adder: accumulates the weighted sum or applies a saturating weight step.
module ptuc_alu (
	input  ptuc_pkg::alu_ctrl_t                    ctrl,
	input  logic signed [ptuc_pkg::ACC_W-1:0]      acc,
	input  logic signed [ptuc_pkg::WEIGHT_W-1:0]   weight,
	input  logic signed [ptuc_pkg::ACC_W-1:0]      step,
	output logic signed [ptuc_pkg::ACC_W-1:0]      sum,
	output logic signed [ptuc_pkg::WEIGHT_W-1:0]   sat_weight
);
	import ptuc_pkg::*;

	localparam logic signed [ACC_W-1:0] W_MAX = ACC_W'((1 << (WEIGHT_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] W_MIN = -ACC_W'(1 << (WEIGHT_W - 1));

	logic signed [ACC_W-1:0] wext;
	logic signed [ACC_W-1:0] op_a;
	logic signed [ACC_W-1:0] op_b;

	// Select operands: accumulate weight into sum, or add step to weight
	always_comb begin
		wext = ACC_W'(weight);
		if (ctrl.accumulate) begin
			op_a = acc;
			op_b = ctrl.active ? wext : '0;
		end else begin
			op_a = wext;
			op_b = ctrl.active ? step : '0;
		end
		sum = op_a + op_b;
	end

	// Clamp to the weight range
	always_comb begin
		if (sum > W_MAX) begin
			sat_weight = W_MAX[WEIGHT_W-1:0];
		end else if (sum < W_MIN) begin
			sat_weight = W_MIN[WEIGHT_W-1:0];
		end else begin
			sat_weight = sum[WEIGHT_W-1:0];
		end
	end

endmodule

/* rtl/perceptron_train_until_correct.sv */
// Perceptron that retrains on each item until its prediction matches the target.
// Each item gets a sum pass over the weights; while the prediction is wrong
// and the epoch cap is not reached, an update pass and another sum pass follow.
// A new item waits until the previous one is done, and longer while the previous
// result is still stalled; the single shared adder visits one weight per cycle.
// Reset: weights return to 0.5 (saturated), learning_rate to 123, block idle.
module perceptron_train_until_correct #(
	parameter int MAX_EPOCHS = ptuc_pkg::DEF_MAX_EPOCHS,
	parameter int FRAC_BITS  = ptuc_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  ptuc_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output ptuc_pkg::result_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ptuc_pkg::RATE_W-1:0]   cfg_data
);
	import ptuc_pkg::*;

	localparam int EPOCH_W = $clog2(MAX_EPOCHS + 1);
	localparam int HALF_I  = (FRAC_BITS - 1 >= WEIGHT_W - 1) ?
	                         ((1 << (WEIGHT_W - 1)) - 1) : (1 << (FRAC_BITS - 1));
	localparam logic signed [WEIGHT_W-1:0] HALF_W = WEIGHT_W'(HALF_I);
	localparam logic [EPOCH_W-1:0] EPOCH_CAP = EPOCH_W'(MAX_EPOCHS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                  state_q;
	logic [IDX_W-1:0]            idx_q;
	logic [NUM_W-1:0]            feat_q;
	logic                        want_q;
	logic                        first_pass_q;
	logic                        first_q;
	logic                        pred_q;
	logic [EPOCH_W-1:0]          epochs_q;
	logic [CORR_W-1:0]           count_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [WEIGHT_W-1:0]  weight_q [NUM_W];
	logic [RATE_W-1:0]           rate_q;
	logic                        result_valid_q;
	result_t                     result_q;

	alu_ctrl_t                   alu_ctrl;
	logic signed [ACC_W-1:0]     step;
	logic signed [ACC_W-1:0]     alu_sum;
	logic signed [WEIGHT_W-1:0]  alu_sat;
	logic                        pred_now;
	logic                        item_fire;
	logic                        last_idx;

	assign item_stall   = (state_q != ST_IDLE);
	assign item_fire    = item_valid && !item_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign last_idx     = (idx_q == BIAS_IDX);

	// Form the signed step and the adder controls
	always_comb begin
		step = want_q ? $signed(ACC_W'(rate_q)) : -$signed(ACC_W'(rate_q));
		alu_ctrl.accumulate = (state_q == ST_SUM);
		alu_ctrl.active     = feat_q[idx_q];
		pred_now            = (alu_sum > 0);
	end

	ptuc_alu u_alu (
		.ctrl       (alu_ctrl),
		.acc        (acc_q),
		.weight     (weight_q[idx_q]),
		.step       (step),
		.sum        (alu_sum),
		.sat_weight (alu_sat)
	);

	// Hold the learning rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rate_q <= cfg_data;
		end
	end

	// Sequence sum and update passes over the weights
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			idx_q          <= '0;
			first_pass_q   <= 1'b0;
			epochs_q       <= '0;
			count_q        <= '0;
			result_valid_q <= 1'b0;
			for (int i = 0; i < NUM_W; i++) begin
				weight_q[i] <= HALF_W;
			end
		end else begin
			// Drop valid once the result transaction is taken, unless a new one loads
			if (result_valid_q && !result_stall && state_q != ST_DONE) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_fire) begin
						feat_q       <= {1'b1, item.habitat_wild, item.body_size,
						                 item.prey_size, item.tame_flag};
						want_q       <= item.desired_class;
						acc_q        <= '0;
						idx_q        <= '0;
						epochs_q     <= '0;
						count_q      <= '0;
						first_pass_q <= 1'b1;
						state_q      <= ST_SUM;
					end
				end
				ST_SUM: begin
					acc_q <= alu_sum;
					if (last_idx) begin
						idx_q        <= '0;
						pred_q       <= pred_now;
						first_pass_q <= 1'b0;
						if (first_pass_q) begin
							first_q <= pred_now;
						end
						if (pred_now == want_q || epochs_q == EPOCH_CAP) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_UPD;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_UPD: begin
					weight_q[idx_q] <= alu_sat;
					if (last_idx) begin
						idx_q    <= '0;
						acc_q    <= '0;
						epochs_q <= epochs_q + 1'b1;
						if (count_q != CORR_MAX) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_SUM;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (!result_valid_q || !result_stall) begin
						result_q.first_class <= first_q;
						result_q.corrections <= count_q;
						result_q.cap_hit     <= (pred_q != want_q);
						result_q.final_class <= pred_q;
						result_valid_q       <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/ptuc_checker.sv */
// Port-level checks for the perceptron training block, bound to the top level.
module ptuc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input ptuc_pkg::result_t result
);
	import ptuc_pkg::*;

	// Hold a stalled result transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// Go busy after accepting an item
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item accepted while not going busy");

	// A new result only comes out of a busy period
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without an item in work");

	// No correction means the prediction never changed
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.corrections == '0 |->
		result.first_class == result.final_class)
		else $error("class changed without a correction");

	// Hitting the cap implies corrections were made
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.cap_hit |-> result.corrections != '0)
		else $error("cap hit with zero corrections");

endmodule

bind perceptron_train_until_correct ptuc_checker u_ptuc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
